@@ rtl/radial_tukey_sample_weight_unit_defines.svh @@
// Assertion macros for the checker file of the radial Tukey weight unit.
`ifndef RADIAL_TUKEY_SAMPLE_WEIGHT_UNIT_DEFINES_SVH
`define RADIAL_TUKEY_SAMPLE_WEIGHT_UNIT_DEFINES_SVH

// General concurrent assertion on a clock, disabled while reset is low.
`define RTSW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds its value in the cycle after a condition was seen.
`define RTSW_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

@@ rtl/rtsw_pkg.sv @@
// ----------------------------------------------------------------------------
// rtsw_pkg
// Shared constants, types and the taper polynomial coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rtsw_pkg;

	// Default field widths.
	localparam int COORD_BITS_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	// Configuration port.
	localparam int REG_W = 16;
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_START  = 2'd0;
	localparam logic [IDX_W-1:0] REG_END    = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [REG_W-1:0] START_RST  = 16'd0;
	localparam logic [REG_W-1:0] END_RST    = 16'd4096;
	localparam logic [REG_W-1:0] HEIGHT_RST = 16'd0;

	// Weight format Q1.15: unity.
	localparam logic [15:0] W_ONE = 16'h8000;

	// Taper position and polynomial formats.
	localparam int QW    = 17;
	localparam int PW    = 30;
	localparam int VW    = 32;
	localparam int PRODW = PW + VW;
	localparam logic [QW-1:0] U_HALF = 17'd32768;
	localparam logic [QW-1:0] U_FULL = 17'd65536;

	localparam logic [PW-1:0] ONE_Q28 = 30'd268435456;
	localparam logic [PW-1:0] COEF_B1 = 30'd662337939;
	localparam logic [PW-1:0] COEF_B2 = 30'd544751120;
	localparam logic [PW-1:0] COEF_B3 = 30'd179215935;
	localparam logic [PW-1:0] COEF_B4 = 30'd31585276;
	localparam logic [PW-1:0] COEF_B5 = 30'd3463742;
	localparam int N_TERMS = 5;

	// Weight classes decided from the radius.
	localparam logic [1:0] MODE_ZERO  = 2'd0;
	localparam logic [1:0] MODE_ONE   = 2'd1;
	localparam logic [1:0] MODE_TAPER = 2'd2;

	typedef struct packed {
		logic [REG_W-1:0] start_radius;
		logic [REG_W-1:0] end_radius;
		logic [REG_W-1:0] edge_height;
	} cfg_t;

	// Constant subtracted at each Horner step, innermost first.
	function automatic logic [PW-1:0] poly_coef(input int k);
		logic [PW-1:0] c;
		unique case (k)
			0: c = COEF_B4;
			1: c = COEF_B3;
			2: c = COEF_B2;
			3: c = COEF_B1;
			default: c = ONE_Q28;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/rtsw_radius.sv @@
// ----------------------------------------------------------------------------
// rtsw_radius
// Sum of squares of three coordinates and a one-bit-per-stage square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rtsw_radius #(
	parameter int CB    = 16,
	parameter int TAG_W = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           ce,
	input  wire logic           in_valid,
	input  wire logic [CB-1:0]  coord_x,
	input  wire logic [CB-1:0]  coord_y,
	input  wire logic [CB-1:0]  coord_z,
	input  wire logic [TAG_W-1:0] in_tag,
	output logic                out_valid,
	output logic [CB:0]         radius,
	output logic [TAG_W-1:0]    out_tag
);
	import rtsw_pkg::*;

	localparam int RB = CB + 1;
	localparam int SW = 2 * RB;
	localparam int RW = RB + 2;

	logic [CB-1:0] mx_s1, my_s1, mz_s1;
	logic [2*CB-1:0] sx_s2, sy_s2, sz_s2;
	logic [TAG_W-1:0] tag_s1, tag_s2;
	logic vld_s1, vld_s2;

	logic [SW-1:0] sqrt_rad_s [RB+1];
	logic [RW-1:0] sqrt_rem_s [RB+1];
	logic [RB-1:0] sqrt_root_s [RB+1];
	logic [TAG_W-1:0] sqrt_tag_s [RB+1];
	logic sqrt_vld_s [RB+1];

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			sqrt_vld_s[0] <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			sqrt_vld_s[0] <= vld_s2;
		end
	end

	// Magnitudes, squares and their sum.
	always_ff @(posedge clk) begin
		if (ce) begin
			mx_s1 <= coord_x[CB-1] ? (CB'(0) - coord_x) : coord_x;
			my_s1 <= coord_y[CB-1] ? (CB'(0) - coord_y) : coord_y;
			mz_s1 <= coord_z[CB-1] ? (CB'(0) - coord_z) : coord_z;
			tag_s1 <= in_tag;
			sx_s2 <= mx_s1 * mx_s1;
			sy_s2 <= my_s1 * my_s1;
			sz_s2 <= mz_s1 * mz_s1;
			tag_s2 <= tag_s1;
			sqrt_rad_s[0] <= SW'(sx_s2) + SW'(sy_s2) + SW'(sz_s2);
			sqrt_rem_s[0] <= '0;
			sqrt_root_s[0] <= '0;
			sqrt_tag_s[0] <= tag_s2;
		end
	end

	// Square root: each stage brings in two radicand bits and settles one root bit.
	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		logic ge;

		always_comb begin
			rem_sh = {sqrt_rem_s[k][RW-3:0], sqrt_rad_s[k][SW-1:SW-2]};
			trial  = {sqrt_root_s[k], 2'b01} ;
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqrt_vld_s[k+1] <= 1'b0;
			end else if (ce) begin
				sqrt_vld_s[k+1] <= sqrt_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				sqrt_rad_s[k+1]  <= {sqrt_rad_s[k][SW-3:0], 2'b00};
				sqrt_rem_s[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
				sqrt_root_s[k+1] <= {sqrt_root_s[k][RB-2:0], ge};
				sqrt_tag_s[k+1]  <= sqrt_tag_s[k];
			end
		end
	end

	assign out_valid = sqrt_vld_s[RB];
	assign radius    = sqrt_root_s[RB];
	assign out_tag   = sqrt_tag_s[RB];

endmodule
`default_nettype wire

@@ rtl/rtsw_taper.sv @@
// ----------------------------------------------------------------------------
// rtsw_taper
// Radius classification, taper position divider and raised-cosine weight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rtsw_taper #(
	parameter int RB    = 17,
	parameter int TAG_W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ce,
	input  wire rtsw_pkg::cfg_t   cfg,
	input  wire logic             in_valid,
	input  wire logic [RB-1:0]    radius,
	input  wire logic [TAG_W-1:0] in_tag,
	output logic                  out_valid,
	output logic [15:0]           weight,
	output logic [TAG_W-1:0]      out_tag
);
	import rtsw_pkg::*;

	localparam int CMPW = (RB > REG_W) ? RB : REG_W;

	logic [CMPW-1:0] r_c, start_c, end_c;
	logic [1:0] mode_c;
	logic [15:0] h_clip;
	logic [15:0] h_rest;

	logic [QW-1:0] div_rem_s [QW+1];
	logic [QW-1:0] div_q_s [QW+1];
	logic [REG_W-1:0] div_d_s [QW+1];
	logic [1:0] div_mode_s [QW+1];
	logic [TAG_W-1:0] div_tag_s [QW+1];
	logic div_vld_s [QW+1];

	logic [15:0] a_p1;
	logic flip_p1, flip_p2;
	logic [1:0] mode_p1, mode_p2;
	logic [TAG_W-1:0] tag_p1;
	logic vld_p1;

	logic [PW-1:0] poly_p_s [N_TERMS+1];
	logic [VW-1:0] poly_v_s [N_TERMS+1];
	logic poly_flip_s [N_TERMS+1];
	logic [1:0] poly_mode_s [N_TERMS+1];
	logic [TAG_W-1:0] poly_tag_s [N_TERMS+1];
	logic poly_vld_s [N_TERMS+1];

	logic [PW-1:0] c_val;
	logic [44:0] wprod_w1;
	logic [1:0] mode_w1;
	logic [TAG_W-1:0] tag_w1, tag_w2;
	logic vld_w1, vld_w2;
	logic [15:0] w_w2;
	logic [45:0] w_round;

	// Edge height is clipped to unity.
	always_comb begin
		h_clip = (cfg.edge_height > W_ONE) ? W_ONE : cfg.edge_height;
		h_rest = W_ONE - h_clip;
	end

	// Classify the radius against the two registers.
	always_comb begin
		r_c     = CMPW'(radius);
		start_c = CMPW'(cfg.start_radius);
		end_c   = CMPW'(cfg.end_radius);
		if (r_c > end_c) begin
			mode_c = MODE_ZERO;
		end else if (r_c <= start_c) begin
			mode_c = MODE_ONE;
		end else begin
			mode_c = MODE_TAPER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (ce) begin
			div_vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			div_rem_s[0]  <= QW'(REG_W'(r_c) - cfg.start_radius);
			div_q_s[0]    <= '0;
			div_d_s[0]    <= cfg.end_radius - cfg.start_radius;
			div_mode_s[0] <= mode_c;
			div_tag_s[0]  <= in_tag;
		end
	end

	// Restoring divider for (r - start) * 2^16 / (end - start), one quotient bit a stage.
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [QW-1:0] rem_t;
		logic ge;

		if (j == 0) begin : g_first
			assign rem_t = div_rem_s[j];
		end else begin : g_shift
			assign rem_t = {div_rem_s[j][QW-2:0], 1'b0};
		end
		assign ge = rem_t >= {1'b0, div_d_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[j+1] <= 1'b0;
			end else if (ce) begin
				div_vld_s[j+1] <= div_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				div_rem_s[j+1]  <= ge ? (rem_t - {1'b0, div_d_s[j]}) : rem_t;
				div_q_s[j+1]    <= {div_q_s[j][QW-2:0], ge};
				div_d_s[j+1]    <= div_d_s[j];
				div_mode_s[j+1] <= div_mode_s[j];
				div_tag_s[j+1]  <= div_tag_s[j];
			end
		end
	end

	// Fold the position into the first half and square it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			poly_vld_s[0] <= 1'b0;
		end else if (ce) begin
			vld_p1 <= div_vld_s[QW];
			poly_vld_s[0] <= vld_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			flip_p1 <= div_q_s[QW] > U_HALF;
			a_p1    <= (div_q_s[QW] > U_HALF) ? 16'(U_FULL - div_q_s[QW])
				: div_q_s[QW][15:0];
			mode_p1 <= div_mode_s[QW];
			tag_p1  <= div_tag_s[QW];
			poly_v_s[0]    <= a_p1 * a_p1;
			poly_p_s[0]    <= COEF_B5;
			poly_flip_s[0] <= flip_p1;
			poly_mode_s[0] <= mode_p1;
			poly_tag_s[0]  <= tag_p1;
		end
	end

	// Horner steps: a multiply stage, then a subtract stage.
	for (genvar k = 0; k < N_TERMS; k++) begin : g_poly
		logic [PRODW-1:0] prod_sa;
		logic [VW-1:0] v_sa;
		logic flip_sa;
		logic [1:0] mode_sa;
		logic [TAG_W-1:0] tag_sa;
		logic vld_sa;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sa <= 1'b0;
				poly_vld_s[k+1] <= 1'b0;
			end else if (ce) begin
				vld_sa <= poly_vld_s[k];
				poly_vld_s[k+1] <= vld_sa;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				prod_sa <= poly_p_s[k] * poly_v_s[k];
				v_sa    <= poly_v_s[k];
				flip_sa <= poly_flip_s[k];
				mode_sa <= poly_mode_s[k];
				tag_sa  <= poly_tag_s[k];
				poly_p_s[k+1]    <= poly_coef(k) - prod_sa[PRODW-1:VW];
				poly_v_s[k+1]    <= v_sa;
				poly_flip_s[k+1] <= flip_sa;
				poly_mode_s[k+1] <= mode_sa;
				poly_tag_s[k+1]  <= tag_sa;
			end
		end
	end

	// Mirror for the second half, then blend between the edge height and unity.
	assign c_val   = poly_flip_s[N_TERMS] ? (ONE_Q28 - poly_p_s[N_TERMS])
		: poly_p_s[N_TERMS];
	assign w_round = 46'(wprod_w1) + 46'(1 << 27);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_w1 <= 1'b0;
			vld_w2 <= 1'b0;
		end else if (ce) begin
			vld_w1 <= poly_vld_s[N_TERMS];
			vld_w2 <= vld_w1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			wprod_w1 <= h_rest * c_val[28:0];
			mode_w1  <= poly_mode_s[N_TERMS];
			tag_w1   <= poly_tag_s[N_TERMS];
			tag_w2   <= tag_w1;
			unique case (mode_w1)
				MODE_ZERO:  w_w2 <= 16'd0;
				MODE_ONE:   w_w2 <= W_ONE;
				MODE_TAPER: w_w2 <= h_clip + w_round[43:28];
				default:    w_w2 <= 16'd0;
			endcase
		end
	end

	assign out_valid = vld_w2;
	assign weight    = w_w2;
	assign out_tag   = tag_w2;

endmodule
`default_nettype wire

@@ rtl/rtsw_scale.sv @@
// ----------------------------------------------------------------------------
// rtsw_scale
// Multiplies both sample parts by the weight with rounding to nearest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rtsw_scale #(
	parameter int SB = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          ce,
	input  wire logic          in_valid,
	input  wire logic [15:0]   weight,
	input  wire logic [SB-1:0] sample_re,
	input  wire logic [SB-1:0] sample_im,
	output logic               out_valid,
	output logic [SB-1:0]      out_re,
	output logic [SB-1:0]      out_im
);
	import rtsw_pkg::*;

	localparam int MW = SB + 16;

	logic [SB-1:0] mre_s1, mim_s1;
	logic nre_s1, nim_s1, nre_s2, nim_s2;
	logic [15:0] w_s1;
	logic [MW-1:0] pre_s2, pim_s2;
	logic [MW-1:0] rre, rim;
	logic [SB-1:0] out_re_s3, out_im_s3;
	logic vld_s1, vld_s2, vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Round the magnitude product, then restore the sign.
	assign rre = (pre_s2 + MW'(16384)) >> 15;
	assign rim = (pim_s2 + MW'(16384)) >> 15;

	always_ff @(posedge clk) begin
		if (ce) begin
			nre_s1 <= sample_re[SB-1];
			nim_s1 <= sample_im[SB-1];
			mre_s1 <= sample_re[SB-1] ? (SB'(0) - sample_re) : sample_re;
			mim_s1 <= sample_im[SB-1] ? (SB'(0) - sample_im) : sample_im;
			w_s1   <= weight;
			pre_s2 <= mre_s1 * w_s1;
			pim_s2 <= mim_s1 * w_s1;
			nre_s2 <= nre_s1;
			nim_s2 <= nim_s1;
			out_re_s3 <= nre_s2 ? (SB'(0) - rre[SB-1:0]) : rre[SB-1:0];
			out_im_s3 <= nim_s2 ? (SB'(0) - rim[SB-1:0]) : rim[SB-1:0];
		end
	end

	assign out_valid = vld_s3;
	assign out_re    = out_re_s3;
	assign out_im    = out_im_s3;

endmodule
`default_nettype wire

@@ rtl/radial_tukey_sample_weight_unit.sv @@
// ----------------------------------------------------------------------------
// radial_tukey_sample_weight_unit
// Radial Tukey taper weighting of complex k-space samples.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock cycle while the output is not
// stalled and returns one weighted sample per input, in order. The pipeline
// has magnitude, square and sum stages, COORD_BITS + 1 square-root stages,
// one classification stage, seventeen divider stages, two stages to fold
// and square the taper position, ten stages of polynomial multiply and
// subtract, two weight stages and three scaling stages. The whole pipeline
// advances together and holds while a result waits at the output register,
// so nothing is lost or repeated.
// Configuration should be written only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none
module radial_tukey_sample_weight_unit #(
	parameter int COORD_BITS  = rtsw_pkg::COORD_BITS_DEF,
	parameter int SAMPLE_BITS = rtsw_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// Fields from bit 0: coord_x, coord_y, coord_z, sample_re, sample_im.
	input  wire logic [((3*COORD_BITS+2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// Fields from bit 0: out_re, out_im.
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire logic cfg_we,
	input  wire logic [rtsw_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [rtsw_pkg::REG_W-1:0] cfg_wdata
);
	import rtsw_pkg::*;

	localparam int CB    = COORD_BITS;
	localparam int SB    = SAMPLE_BITS;
	localparam int RB    = CB + 1;
	localparam int TAG_W = 2 * SB;
	localparam int OUT_W = ((2*SB+7)/8)*8;

	logic [REG_W-1:0] start_q, end_q, height_q;
	cfg_t cfg;
	logic ce;

	logic rad_valid;
	logic [RB-1:0] rad;
	logic [TAG_W-1:0] rad_tag;
	logic tap_valid;
	logic [15:0] tap_weight;
	logic [TAG_W-1:0] tap_tag;
	logic [SB-1:0] res_re, res_im;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_RST;
			end_q    <= END_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START:  start_q  <= cfg_wdata;
				REG_END:    end_q    <= cfg_wdata;
				REG_HEIGHT: height_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	assign cfg = '{start_radius: start_q, end_radius: end_q, edge_height: height_q};

	// The pipeline moves whenever the output register is free or being emptied.
	assign ce       = m_tready || !m_tvalid;
	assign s_tready = ce;

	rtsw_radius #(.CB(CB), .TAG_W(TAG_W)) u_radius (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (s_tvalid),
		.coord_x  (s_tdata[CB-1:0]),
		.coord_y  (s_tdata[2*CB-1:CB]),
		.coord_z  (s_tdata[3*CB-1:2*CB]),
		.in_tag   (s_tdata[3*CB+2*SB-1:3*CB]),
		.out_valid(rad_valid),
		.radius   (rad),
		.out_tag  (rad_tag)
	);

	rtsw_taper #(.RB(RB), .TAG_W(TAG_W)) u_taper (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.cfg      (cfg),
		.in_valid (rad_valid),
		.radius   (rad),
		.in_tag   (rad_tag),
		.out_valid(tap_valid),
		.weight   (tap_weight),
		.out_tag  (tap_tag)
	);

	rtsw_scale #(.SB(SB)) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (tap_valid),
		.weight   (tap_weight),
		.sample_re(tap_tag[SB-1:0]),
		.sample_im(tap_tag[2*SB-1:SB]),
		.out_valid(m_tvalid),
		.out_re   (res_re),
		.out_im   (res_im)
	);

	assign m_tdata = OUT_W'({res_im, res_re});

endmodule
`default_nettype wire

@@ rtl/rtsw_checker.sv @@
// ----------------------------------------------------------------------------
// rtsw_checker
// Port-level checks of the output handshake and pipeline flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "radial_tukey_sample_weight_unit_defines.svh"
module rtsw_checker #(
	parameter int OUT_W = 32
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	// A stalled result stays offered and unchanged.
	`RTSW_ASSERT_HOLD(a_valid_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`RTSW_ASSERT_HOLD(a_data_hold, clk, arst_n, m_tvalid && !m_tready, m_tdata, "result changed while stalled")

	// Input is taken whenever the output side can move.
	`RTSW_ASSERT(a_ready_empty, clk, arst_n, !m_tvalid |-> s_tready, "input blocked with empty output")
	`RTSW_ASSERT(a_ready_flow, clk, arst_n, m_tready |-> s_tready, "input blocked while output drains")

endmodule

bind radial_tukey_sample_weight_unit rtsw_checker #(.OUT_W(OUT_W)) u_rtsw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

@@ test/radial_tukey_sample_weight_checker.sv @@
// ----------------------------------------------------------------------------
// radial_tukey_sample_weight_checker
// Watches the input, output and register channels of the radial Tukey weight
// unit, works out the weighted sample for every accepted input transaction
// and compares each output transaction with the oldest pending weighted sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module radial_tukey_sample_weight_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [79:0] s_tdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic        cfg_we,
	input  wire logic [rtsw_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [rtsw_pkg::REG_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending_count
);
	import rtsw_pkg::*;

	typedef struct packed {
		logic [15:0] im;
		logic [15:0] re;
	} weighted_t;

	weighted_t   pending_q[$];
	logic [15:0] taper_start;
	logic [15:0] taper_end;
	logic [15:0] taper_height;

	assign pending_count = pending_q.size();

	// Integer square root of a 64-bit value.
	function automatic logic [63:0] root_of(input logic [63:0] n);
		logic [63:0] rem, res, b;
		rem = n;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Raised cosine (1+cos(pi*u))/2 in Q28 for a Q16 position.
	function automatic logic [63:0] raised_cosine(input logic [63:0] u);
		logic        flip;
		logic [63:0] a, v, p;
		flip = u > 32768;
		a = flip ? 64'd65536 - u : u;
		v = a * a;
		p = COEF_B5;
		p = COEF_B4 - ((p * v) >> 32);
		p = COEF_B3 - ((p * v) >> 32);
		p = COEF_B2 - ((p * v) >> 32);
		p = COEF_B1 - ((p * v) >> 32);
		p = ONE_Q28 - ((p * v) >> 32);
		return flip ? ONE_Q28 - p : p;
	endfunction

	// Q1.15 taper weight for a Q4.12 radius.
	function automatic logic [63:0] taper_weight(input logic [63:0] r);
		logic [63:0] h, u;
		h = (taper_height > 32768) ? 64'd32768 : 64'(taper_height);
		if (r > taper_end) return 0;
		if (r <= taper_start) return 32768;
		u = ((r - taper_start) << 16) / (taper_end - taper_start);
		return h + (((64'd32768 - h) * raised_cosine(u) + (64'd1 << 27)) >> 28);
	endfunction

	// Sample times weight, rounded to nearest with ties away from zero.
	function automatic logic [15:0] scaled(input logic [15:0] s, input logic [63:0] w);
		logic [63:0] m, q;
		m = s[15] ? 64'(-$signed({1'b1, s})) & 64'hFFFF : 64'(s);
		if (s == 16'h8000) m = 32768;
		q = (m * w + 16384) >> 15;
		if (s[15]) q = -q;
		return q[15:0];
	endfunction

	function automatic weighted_t weigh_sample(input logic [79:0] d);
		logic [63:0] sum, sq, m, w;
		weighted_t   res;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m = d[i*16+15] ? 64'(17'h10000 - {1'b0, d[i*16 +: 16]}) : 64'(d[i*16 +: 16]);
			sq = m * m;
			sum = (sum + sq < sum) ? '1 : sum + sq;
		end
		w = taper_weight(root_of(sum));
		res.re = scaled(d[63:48], w);
		res.im = scaled(d[79:64], w);
		return res;
	endfunction

	// Track registers, queue predictions and compare results.
	always @(posedge clk or negedge arst_n) begin
		weighted_t got, want;
		int        errs;
		errs = 0;
		if (!arst_n) begin
			taper_start <= START_RST;
			taper_end <= END_RST;
			taper_height <= HEIGHT_RST;
			pending_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START:  taper_start <= cfg_wdata;
					REG_END:    taper_end <= cfg_wdata;
					REG_HEIGHT: taper_height <= cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) pending_q.push_back(weigh_sample(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected transaction, got %h", $time, got);
					errs++;
				end else begin
					want = pending_q.pop_front();
					if (got.re !== want.re) begin
						$display("%0t: out_re expected %h, got %h", $time, want.re, got.re);
						errs++;
					end
					if (got.im !== want.im) begin
						$display("%0t: out_im expected %h, got %h", $time, want.im, got.im);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end

endmodule

@@ test/tb_radial_tukey_sample_weight_unit.sv @@
// ----------------------------------------------------------------------------
// tb_radial_tukey_sample_weight_unit
// Drives directed and random samples through the weight unit across several
// taper settings, with bursty input and a stalling output; the checker
// compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_radial_tukey_sample_weight_unit;
	import rtsw_pkg::*;

	localparam int LATENCY = 55;
	// Register index past the end of the list; writes to it are dropped.
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	logic             clk = 0;
	logic             arst_n = 0;
	logic [79:0]      s_tdata = '0;
	logic             s_tvalid = 0;
	logic             s_tready;
	logic [31:0]      m_tdata;
	logic             m_tvalid;
	logic             m_tready = 0;
	logic             cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = REG_START;
	logic [REG_W-1:0] cfg_wdata = '0;
	int               fail_count;
	int               pending_count;
	int               stall_mode;

	always #5 clk = ~clk;

	radial_tukey_sample_weight_unit u_dut (.*);
	radial_tukey_sample_weight_checker u_chk (.*);

	// Output stall pattern, switching between free, light and heavy stalls.
	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0:       m_tready <= 1;
			1:       m_tready <= $urandom_range(0, 3) != 0;
			default: m_tready <= $urandom_range(0, 3) == 0;
		endcase
	end

	// One register write; the caller drops the write enable after the last one.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_taper(input logic [15:0] st, input logic [15:0] en,
			input logic [15:0] ht);
		write_reg(REG_START, st);
		write_reg(REG_END, en);
		write_reg(REG_HEIGHT, ht);
		write_reg(REG_UNUSED, 16'($urandom));
		cfg_we <= 0;
	endtask

	// Send one transaction, holding valid until it is accepted.
	task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic [15:0] re, input logic [15:0] im);
		s_tdata <= {im, re, z, y, x};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		while (pending_count != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [15:0] coord_near(input logic [15:0] rad);
		logic [16:0] c;
		c = {1'b0, rad} / 2 + 17'($urandom_range(0, 2000));
		if (c > 32767) c = 32767;
		return $urandom_range(0, 1) ? -c[15:0] : c[15:0];
	endfunction

	task automatic random_phase(input int n, input logic [15:0] rad);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && n > 0) begin
				if ($urandom_range(0, 2) == 0)
					send_sample(16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom));
				else
					send_sample(coord_near(rad), coord_near(rad), coord_near(rad),
						16'($urandom), 16'($urandom));
				burst--;
				n--;
			end
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: extreme coordinates and samples at the reset taper.
		send_sample(0, 0, 0, 16'h7FFF, 16'h8000);
		send_sample(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1);
		send_sample(16'd2048, 0, 0, 16'h8000, 16'h7FFF);
		send_sample(0, 16'hF800, 0, 3, 16'hFFFD);
		send_sample(0, 0, 16'd4096, 16'h7FFF, 16'h7FFF);
		send_sample(0, 0, 16'd4097, 16'h7FFF, 16'h7FFF);
		s_tvalid <= 0;
		drain();
		// Equal radii: a step from one to zero.
		set_taper(16'd8192, 16'd8192, 16'd16384);
		send_sample(16'd8192, 0, 0, 16'h7FFF, 16'h8000);
		send_sample(16'd8193, 0, 0, 16'h7FFF, 16'h8000);
		send_sample(16'd8191, 0, 0, 16'h7FFF, 16'h8000);
		s_tvalid <= 0;
		drain();
		// Start above end, and height above one.
		set_taper(16'd12000, 16'd4000, 16'hFFFF);
		send_sample(16'd3000, 0, 0, 16'h7FFF, 16'h8000);
		send_sample(16'd8000, 0, 0, 16'h7FFF, 16'h8000);
		send_sample(16'd12000, 0, 0, 16'h7FFF, 16'h8000);
		s_tvalid <= 0;
		drain();
		// Taper end points with full and mid height.
		set_taper(16'd0, 16'hFFFF, 16'h8000);
		send_sample(16'd20000, 16'd20000, 0, 16'h7FFF, 16'h8000);
		s_tvalid <= 0;
		drain();
		set_taper(16'd4096, 16'd12288, 16'd16384);
		send_sample(16'd12288, 0, 0, 16'h7FFF, 16'h8000);
		send_sample(16'd8192, 0, 0, 16'h7FFF, 16'h8000);
		send_sample(16'd4097, 0, 0, 16'h7FFF, 16'h8000);
		s_tvalid <= 0;
		drain();
		// Random phases over several taper settings.
		random_phase(120, 16'd8000);
		drain();
		set_taper(16'd0, 16'hFFFF, 16'd0);
		random_phase(120, 16'd30000);
		drain();
		set_taper(16'hFFFF, 16'hFFFF, 16'h8000);
		random_phase(60, 16'd30000);
		drain();
		for (int i = 0; i < 3; i++) begin
			set_taper(16'($urandom_range(0, 20000)), 16'($urandom_range(20000, 65535)),
				16'($urandom_range(0, 32768)));
			random_phase(100, 16'd20000);
			drain();
		end
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
